/* rtl/core/pmjf_pkg.sv */
package pmjf_pkg;

    // fixed field widths
    localparam int ROW_W = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;

    // element count after reset
    localparam logic [CNT_W-1:0] COUNT_RESET = 6'd32;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic write_row;
        logic start_query;
        logic load_rows;
        logic scan_step;
        logic pop_fetch;
        logic pop_reload;
        logic emit_scan;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic trivial;
        logic scan_end;
        logic pop;
    } t_status;

    // relation bit of a row, zero for columns past the row width
    function automatic logic row_bit(logic [ROW_W-1:0] row, logic [6:0] idx);
        logic r;
        r = 1'b0;
        if (idx < 7'(ROW_W)) begin
            r = row[idx[4:0]];
        end
        return r;
    endfunction

endpackage

/* rtl/core/pmjf_ram.sv */
module pmjf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pmjf_ctrl.sv */
module pmjf_ctrl
    import pmjf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_kind,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_POP1 = 5'b01000,
        ST_POP2 = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.write_row   = accept && (i_kind == KIND_LOAD);
                o_cmd.start_query = accept && (i_kind == KIND_QUERY);
                if (accept && (i_kind == KIND_QUERY)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_rows = 1'b1;
                n_state = i_status.trivial ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    o_cmd.emit_scan = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_status.pop) begin
                        n_state = ST_POP1;
                    end
                end
            end
            ST_POP1: begin
                o_cmd.pop_fetch = 1'b1;
                n_state = ST_POP2;
            end
            ST_POP2: begin
                o_cmd.pop_reload = 1'b1;
                n_state = ST_SCAN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/pmjf_dpath.sv */
module pmjf_dpath
    import pmjf_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0] i_row_index,
    input  logic [ROW_W-1:0] i_row_bits,
    input  logic [IDX_W-1:0] i_left,
    input  logic [IDX_W-1:0] i_right,
    input  logic             i_want_join,
    output logic             o_result_valid,
    output logic [IDX_W-1:0] o_bound_index,
    output logic             o_found
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int EW = (AW > IDX_W) ? AW : IDX_W;

    // registers
    logic [CNT_W-1:0] r_count_cfg, n_count_cfg;
    logic [CW-1:0]    r_count, n_count;
    logic [IDX_W-1:0] r_x, n_x;
    logic [IDX_W-1:0] r_y, n_y;
    logic             r_join, n_join;
    logic             r_range_ok, n_range_ok;
    logic [ROW_W-1:0] r_row_x, n_row_x;
    logic [ROW_W-1:0] r_row_y, n_row_y;
    logic [ROW_W-1:0] r_row_cur, n_row_cur;
    logic [CW-1:0]    r_d, n_d;
    logic [EW-1:0]    r_cur, n_cur;
    logic             r_have, n_have;
    logic [CW-1:0]    r_sp, n_sp;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_bound, n_bound;
    logic             r_found, n_found;

    // memory ports
    logic             row_we;
    logic [AW-1:0]    a_addr, b_addr;
    logic [ROW_W-1:0] q_a, q_b;
    logic             s_we;
    logic [AW-1:0]    s_raddr;
    logic [IDX_W-1:0] s_wdata;
    logic [IDX_W-1:0] q_s;

    // decision terms
    logic [CW-1:0]    eff_count;
    logic             x_le_y, y_le_x;
    logic [IDX_W-1:0] triv_idx;
    logic [6:0]       d7;
    logic             cand, d_le_c, c_le_d, d_better, c_better;
    logic             push;

    // two copies of the relation rows for two read addresses
    assign row_we = i_cmd.write_row && (7'(i_row_index) < 7'(MAX_ELEMENTS));

    pmjf_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ELEMENTS)) u_rows_a (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (AW'(i_row_index)),
        .i_wdata (i_row_bits),
        .i_raddr (a_addr),
        .o_rdata (q_a)
    );

    pmjf_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ELEMENTS)) u_rows_b (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (AW'(i_row_index)),
        .i_wdata (i_row_bits),
        .i_raddr (b_addr),
        .o_rdata (q_b)
    );

    // candidate stack
    pmjf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (AW'(r_sp)),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (q_s)
    );

    // clamp the element count
    assign eff_count = (7'(r_count_cfg) > 7'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS)
                                                             : CW'(r_count_cfg);

    // quick answers from the two operand rows
    assign x_le_y = row_bit(q_a, 7'(r_y));
    assign y_le_x = row_bit(q_b, 7'(r_x));

    always_comb begin
        if (r_x == r_y) begin
            triv_idx = r_x;
        end else if (x_le_y) begin
            triv_idx = r_join ? r_y : r_x;
        end else begin
            triv_idx = r_join ? r_x : r_y;
        end
    end

    assign o_status.trivial = !r_range_ok || (r_x == r_y) || (x_le_y != y_le_x);

    // scan step compare
    assign d7       = 7'(r_d);
    assign cand     = r_join ? (row_bit(r_row_x, d7) && row_bit(r_row_y, d7))
                             : (row_bit(q_a, 7'(r_x)) && row_bit(q_a, 7'(r_y)));
    assign d_le_c   = row_bit(q_a, 7'(r_cur));
    assign c_le_d   = row_bit(r_row_cur, d7);
    assign d_better = r_join ? (d_le_c && !c_le_d) : (c_le_d && !d_le_c);
    assign c_better = r_join ? (c_le_d && !d_le_c) : (d_le_c && !c_le_d);

    assign o_status.scan_end = (r_d == r_count);
    assign o_status.pop      = cand && r_have && !c_better && !d_better && (r_sp != '0);

    // stack write and read
    assign push    = i_cmd.scan_step && cand && r_have && (c_better || d_better);
    assign s_we    = push && (7'(r_sp) < 7'(MAX_ELEMENTS));
    assign s_wdata = c_better ? IDX_W'(r_d) : IDX_W'(r_cur);
    assign s_raddr = AW'(r_sp - CW'(1));

    // row read addresses
    always_comb begin
        a_addr = AW'(r_d);
        b_addr = AW'(r_cur);
        if (i_cmd.start_query) begin
            a_addr = AW'(i_left);
            b_addr = AW'(i_right);
        end else if (i_cmd.load_rows) begin
            a_addr = '0;
        end else if (i_cmd.scan_step) begin
            a_addr = AW'(r_d + CW'(1));
        end else if (i_cmd.pop_fetch) begin
            b_addr = AW'(q_s);
        end
    end

    // next values
    always_comb begin
        n_count_cfg = r_count_cfg;
        n_count     = r_count;
        n_x         = r_x;
        n_y         = r_y;
        n_join      = r_join;
        n_range_ok  = r_range_ok;
        n_row_x     = r_row_x;
        n_row_y     = r_row_y;
        n_row_cur   = r_row_cur;
        n_d         = r_d;
        n_cur       = r_cur;
        n_have      = r_have;
        n_sp        = r_sp;
        n_out_valid = 1'b0;
        n_bound     = r_bound;
        n_found     = r_found;

        // configuration beat
        if (i_cfg_we) begin
            n_count_cfg = i_cfg_data;
        end

        // query accepted
        if (i_cmd.start_query) begin
            n_x        = i_left;
            n_y        = i_right;
            n_join     = i_want_join;
            n_count    = eff_count;
            n_range_ok = (7'(i_left) < 7'(eff_count)) && (7'(i_right) < 7'(eff_count));
        end

        // operand rows arrive
        if (i_cmd.load_rows) begin
            n_row_x = q_a;
            n_row_y = q_b;
            n_d     = '0;
            n_have  = 1'b0;
            n_sp    = '0;
            if (o_status.trivial) begin
                n_out_valid = 1'b1;
                n_found     = r_range_ok;
                n_bound     = r_range_ok ? triv_idx : '0;
            end
        end

        // one element of the scan
        if (i_cmd.scan_step) begin
            n_d = CW'(r_d + CW'(1));
            if (cand) begin
                if (!r_have) begin
                    n_cur     = EW'(r_d);
                    n_have    = 1'b1;
                    n_row_cur = q_a;
                end else if (c_better || d_better) begin
                    if (7'(r_sp) < 7'(MAX_ELEMENTS)) begin
                        n_sp = CW'(r_sp + CW'(1));
                    end
                    if (d_better) begin
                        n_cur     = EW'(r_d);
                        n_row_cur = q_a;
                    end
                end else if (r_sp != '0) begin
                    n_sp = CW'(r_sp - CW'(1));
                end else begin
                    n_have = 1'b0;
                end
            end
        end

        // popped candidate and its row
        if (i_cmd.pop_fetch) begin
            n_cur = EW'(q_s);
        end
        if (i_cmd.pop_reload) begin
            n_row_cur = q_b;
        end

        // scan result
        if (i_cmd.emit_scan) begin
            n_out_valid = 1'b1;
            n_found     = r_have;
            n_bound     = r_have ? IDX_W'(r_cur) : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cfg <= COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count_cfg <= n_count_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_x        <= n_x;
        r_y        <= n_y;
        r_join     <= n_join;
        r_range_ok <= n_range_ok;
        r_row_x    <= n_row_x;
        r_row_y    <= n_row_y;
        r_row_cur  <= n_row_cur;
        r_d        <= n_d;
        r_cur      <= n_cur;
        r_have     <= n_have;
        r_sp       <= n_sp;
        r_bound    <= n_bound;
        r_found    <= n_found;
    end

    assign o_result_valid = r_out_valid;
    assign o_bound_index  = r_bound;
    assign o_found        = r_found;

endmodule

/* rtl/core/poset_meet_join_finder.sv */
// Row load: written at the accepting edge, busy stays low.
// Query: busy from the accepting edge; equal, one-way comparable or out-of-range operands
// give the result strobe from the load state, otherwise from the last scan state.
// The scan reads one relation row per element; each stack pop adds a fetch and a reload state.
// Synchronous active-low reset idles the controller, drops the strobe and sets the
// element count to 32; relation rows are not cleared. Results cannot be stalled.
module poset_meet_join_finder
    import pmjf_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_kind,
    input  logic [IDX_W-1:0] i_row_index,
    input  logic [ROW_W-1:0] i_row_bits,
    input  logic [IDX_W-1:0] i_left,
    input  logic [IDX_W-1:0] i_right,
    input  logic             i_want_join,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_result_valid,
    output logic [IDX_W-1:0] o_bound_index,
    output logic             o_found
);

    t_cmd    cmd;
    t_status status;

    // configuration beats only while idle
    assign o_cfg_ready = !busy;

    // sequencer
    pmjf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // relation store, scan and result registers
    pmjf_dpath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_row_index    (i_row_index),
        .i_row_bits     (i_row_bits),
        .i_left         (i_left),
        .i_right        (i_right),
        .i_want_join    (i_want_join),
        .o_result_valid (o_result_valid),
        .o_bound_index  (o_bound_index),
        .o_found        (o_found)
    );

    // a result is shown only once the query has finished
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted query raises busy in the cycle after it is accepted
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_QUERY)) |=> busy)
        else $error("query did not raise busy");

    // a row load never blocks the next beat
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_LOAD)) |=> (!busy && !o_result_valid))
        else $error("row load raised busy or a result");

    // results are never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two result strobes in a row");

endmodule

/* tb/tb_top.sv */
module tb_top
    import pmjf_pkg::*;
();

    localparam int NUM_ELEMS    = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES  = 120;
    localparam int PRINT_CAP    = 200;

    // one answer of a meet or join query
    typedef struct packed {
        logic [IDX_W-1:0] bound_index;
        logic             found;
    } t_bound;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_kind;
    logic [IDX_W-1:0] i_row_index;
    logic [ROW_W-1:0] i_row_bits;
    logic [IDX_W-1:0] i_left;
    logic [IDX_W-1:0] i_right;
    logic             i_want_join;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;
    logic             o_result_valid;
    logic [IDX_W-1:0] o_bound_index;
    logic             o_found;

    // predictor copy of the relation matrix and the element count
    logic [ROW_W-1:0] order_mem [NUM_ELEMS];
    logic [CNT_W-1:0] count_cfg;

    t_bound bound_queue [$];
    t_bound bound_due;
    int     err_count;
    int     cycle_count;
    int     items_sent;
    int     idle_pct;

    poset_meet_join_finder #(
        .MAX_ELEMENTS(NUM_ELEMS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_row_index   (i_row_index),
        .i_row_bits    (i_row_bits),
        .i_left        (i_left),
        .i_right       (i_right),
        .i_want_join   (i_want_join),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_result_valid(o_result_valid),
        .o_bound_index (o_bound_index),
        .o_found       (o_found)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[poset_meet_join_finder] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want_v);
        if (err_count < PRINT_CAP) begin
            $display("cycle %0d: %s: got %0d, want %0d", cycle_count, what, got, want_v);
        end
        err_count++;
    endtask

    // result checker, one beat per strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (bound_queue.size() == 0) begin
                report_mismatch("result with no query pending", o_bound_index, 0);
            end else begin
                bound_due = bound_queue.pop_front();
                if (o_found !== bound_due.found) begin
                    report_mismatch("found", o_found, bound_due.found);
                end
                if (o_bound_index !== bound_due.bound_index) begin
                    report_mismatch("bound_index", o_bound_index, bound_due.bound_index);
                end
            end
        end
    end

    function automatic logic rel_le(input int a, input int b);
        return order_mem[a][b];
    endfunction

    // meet or join of two elements with a candidate stack over the scan
    function automatic void compute_bound(input int x, input int y, input logic want_j,
                                          output logic [IDX_W-1:0] bound,
                                          output logic found);
        int   eff;
        int   cur;
        int   depth;
        int   stack [NUM_ELEMS];
        logic have;
        logic xy, yx, cand, dc, cd, d_better, c_better;
        eff   = (count_cfg > NUM_ELEMS) ? NUM_ELEMS : int'(count_cfg);
        bound = '0;
        found = 1'b0;
        if (x >= eff || y >= eff) begin
            return;
        end
        if (x == y) begin
            bound = IDX_W'(x);
            found = 1'b1;
            return;
        end
        xy = rel_le(x, y);
        yx = rel_le(y, x);
        if (xy && !yx) begin
            bound = IDX_W'(want_j ? y : x);
            found = 1'b1;
            return;
        end
        if (yx && !xy) begin
            bound = IDX_W'(want_j ? x : y);
            found = 1'b1;
            return;
        end
        // mutual or incomparable: scan for common bounds
        depth = 0;
        have  = 1'b0;
        cur   = 0;
        for (int d = 0; d < eff; d++) begin
            cand = want_j ? (rel_le(x, d) && rel_le(y, d)) : (rel_le(d, x) && rel_le(d, y));
            if (cand) begin
                if (!have) begin
                    cur  = d;
                    have = 1'b1;
                end else begin
                    dc       = rel_le(d, cur);
                    cd       = rel_le(cur, d);
                    d_better = want_j ? (dc && !cd) : (cd && !dc);
                    c_better = want_j ? (cd && !dc) : (dc && !cd);
                    if (c_better) begin
                        if (depth < NUM_ELEMS) begin
                            stack[depth] = d;
                            depth++;
                        end
                    end else if (d_better) begin
                        if (depth < NUM_ELEMS) begin
                            stack[depth] = cur;
                            depth++;
                        end
                        cur = d;
                    end else if (depth > 0) begin
                        depth--;
                        cur = stack[depth];
                    end else begin
                        have = 1'b0;
                    end
                end
            end
        end
        if (have) begin
            bound = IDX_W'(cur);
            found = 1'b1;
        end
    endfunction

    task automatic sender_pause(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // one item beat, prediction taken at the accepting edge
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] row,
                             input logic [ROW_W-1:0] bits, input logic [IDX_W-1:0] lft,
                             input logic [IDX_W-1:0] rgt, input logic wj);
        t_bound           res;
        logic [IDX_W-1:0] b;
        logic             f;
        @(negedge i_clk);
        i_kind      <= kind;
        i_row_index <= row;
        i_row_bits  <= bits;
        i_left      <= lft;
        i_right     <= rgt;
        i_want_join <= wj;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (kind == KIND_LOAD) begin
            order_mem[row] = bits;
        end else begin
            compute_bound(lft, rgt, wj, b, f);
            res.bound_index = b;
            res.found       = f;
            bound_queue.push_back(res);
        end
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            sender_pause($urandom_range(1, 6));
        end
    endtask

    task automatic load_row(input int row, input logic [ROW_W-1:0] bits);
        send_item(KIND_LOAD, IDX_W'(row), bits, IDX_W'($urandom), IDX_W'($urandom),
                  1'($urandom));
    endtask

    task automatic query(input int lft, input int rgt, input logic wj);
        send_item(KIND_QUERY, IDX_W'($urandom), $urandom, IDX_W'(lft), IDX_W'(rgt), wj);
    endtask

    // wait until the block is idle and no answer is outstanding
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (bound_queue.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_cfg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // subset order of the 5-bit indices: a lattice with meet = and, join = or
    function automatic logic [ROW_W-1:0] subset_row(input int a);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int b = 0; b < NUM_ELEMS; b++) begin
            r[b] = ((a & b) == a);
        end
        return r;
    endfunction

    task automatic setup_order();
        for (int r = 0; r < NUM_ELEMS; r++) begin
            load_row(r, subset_row(r));
        end
    endtask

    task automatic test_trivial_answers();
        query(9, 9, 1'b0);
        query(1, 3, 1'b0);
        query(1, 3, 1'b1);
        query(0, 31, 1'b0);
        query(31, 0, 1'b1);
    endtask

    task automatic test_scan_and_pops();
        query(7, 11, 1'b0);
        query(7, 11, 1'b1);
        query(5, 10, 1'b1);
        query(16, 15, 1'b0);
        query(21, 26, 1'b0);
    endtask

    task automatic test_mutual_relation();
        // 31 below everything makes 30 and 31 related both ways
        load_row(31, '1);
        query(30, 31, 1'b1);
        query(30, 31, 1'b0);
        load_row(31, subset_row(31));
        // bottom no longer below anything
        load_row(0, '0);
        query(3, 5, 1'b0);
        load_row(0, subset_row(0));
    endtask

    task automatic test_no_bound();
        write_count(CNT_W'(4));
        for (int r = 0; r < 4; r++) begin
            load_row(r, ROW_W'(1) << r);
        end
        query(1, 2, 1'b0);
        query(2, 3, 1'b1);
        query(5, 1, 1'b0);
    endtask

    task automatic test_count_extremes();
        write_count(CNT_W'(0));
        query(0, 0, 1'b0);
        write_count(CNT_W'(63));
        query(31, 31, 1'b1);
        query(3, 5, 1'b1);
        write_count(COUNT_RESET);
    endtask

    // new relation over the first n rows: mostly partial orders, some noise
    task automatic load_order(input int n);
        logic [ROW_W-1:0] rows [NUM_ELEMS];
        logic [ROW_W-1:0] lowmask;
        int               perm [NUM_ELEMS];
        int               style, p, j, t;
        style   = $urandom_range(0, 9);
        p       = (style == 2) ? 100 : $urandom_range(5, 60);
        lowmask = (n >= NUM_ELEMS) ? '1 : ((ROW_W'(1) << n) - 1);
        for (int i = 0; i < NUM_ELEMS; i++) begin
            perm[i] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < n; i++) begin
            rows[i] = ROW_W'(1) << i;
        end
        if (style <= 1) begin
            for (int i = 0; i < n; i++) begin
                rows[i] = subset_row(i) & lowmask;
            end
        end else if (style <= 7) begin
            // random dag along a shuffled order, then transitive closure
            for (int a = 0; a < n; a++) begin
                for (int b = a + 1; b < n; b++) begin
                    if ($urandom_range(99) < p) begin
                        rows[perm[a]][perm[b]] = 1'b1;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                for (int i = 0; i < n; i++) begin
                    if (rows[i][k]) begin
                        rows[i] = rows[i] | rows[k];
                    end
                end
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                rows[i] = $urandom;
            end
        end
        // columns past the count are never read, fill them with junk
        for (int i = 0; i < n; i++) begin
            rows[i] = rows[i] | ($urandom & ~lowmask);
        end
        for (int i = 0; i < n; i++) begin
            load_row(perm[i], rows[perm[i]]);
        end
    endtask

    task automatic run_queries(input int n, input int qn);
        int   lft, rgt, sel;
        logic wj;
        for (int q = 0; q < qn; q++) begin
            wj  = 1'($urandom);
            sel = $urandom_range(99);
            if (n == 0 || sel < 10) begin
                lft = $urandom_range(0, 31);
                rgt = $urandom_range(0, 31);
            end else begin
                lft = $urandom_range(0, n - 1);
                rgt = (sel < 16) ? lft : $urandom_range(0, n - 1);
            end
            query(lft, rgt, wj);
        end
    endtask

    task automatic test_random(input int pct, input int budget);
        int               first, setting, n;
        logic [CNT_W-1:0] cnt;
        first   = items_sent;
        setting = 0;
        while (items_sent - first < budget) begin
            case (setting)
                0: cnt = CNT_W'(32);
                1: cnt = CNT_W'(1);
                2: cnt = CNT_W'(63);
                3: cnt = CNT_W'(2);
                4: cnt = CNT_W'(0);
                5: cnt = CNT_W'(33);
                default: begin
                    if ($urandom_range(3) < 2) begin
                        cnt = CNT_W'($urandom_range(3, 32));
                    end else if ($urandom_range(1) == 0) begin
                        cnt = CNT_W'(32);
                    end else begin
                        cnt = CNT_W'($urandom_range(0, 63));
                    end
                end
            endcase
            write_count(cnt);
            n = (cnt > NUM_ELEMS) ? NUM_ELEMS : int'(cnt);
            repeat (2) begin
                idle_pct = ($urandom_range(99) < 30) ? 0 : pct;
                load_order(n);
                run_queries(n, $urandom_range(8, 25));
            end
            setting++;
        end
    endtask

    // main sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_kind      = KIND_LOAD;
        i_row_index = '0;
        i_row_bits  = '0;
        i_left      = '0;
        i_right     = '0;
        i_want_join = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        count_cfg   = COUNT_RESET;
        err_count   = 0;
        cycle_count = 0;
        items_sent  = 0;
        idle_pct    = 9;
        for (int r = 0; r < NUM_ELEMS; r++) begin
            order_mem[r] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        setup_order();
        test_trivial_answers();
        test_scan_and_pops();
        test_mutual_relation();
        test_no_bound();
        test_count_extremes();
        test_random(9, 430);
        test_random(59, 430);
        test_random(0, 430);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bound_queue.size() != 0) begin
            report_mismatch("answers never arrived", 0, bound_queue.size());
        end
        if (err_count == 0) begin
            $display("[poset_meet_join_finder] OK");
        end else begin
            $display("[poset_meet_join_finder] ERROR");
        end
        $finish;
    end

endmodule
